FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the five-bar leg block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define FBIK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, held off while in reset.
`define FBIK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/fbik_pkg.sv
// Shared widths, codes and constants of the five-bar leg inverse kinematics block.
// No dependencies; used by the channel interfaces and every RTL module.
package fbik_pkg;

  localparam int COORD_W   = 14;
  localparam int LINK_W    = 13;
  localparam int ANGLE_W   = 18;
  localparam int STATUS_W  = 2;
  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_UPPER_LINK   = 2'd0,
    REG_LOWER_LINK   = 2'd1,
    REG_PIVOT_HEIGHT = 2'd2
  } reg_index_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLAMP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PIVOT = 2'd2;

  localparam logic [LINK_W-1:0] UPPER_LINK_RST   = 13'd1408;
  localparam logic [LINK_W-1:0] LOWER_LINK_RST   = 13'd3200;
  localparam logic [LINK_W-1:0] PIVOT_HEIGHT_RST = 13'd2576;

  // Geometry widths
  localparam int U_W   = 16;            // pivot_height - foot_y
  localparam int AX_W  = 14;            // |foot_x|
  localparam int SQ_W  = 28;            // squares of u and |x|
  localparam int D2_W  = 29;            // squared distance
  localparam int LSQ_W = 2 * LINK_W;    // squared link length
  localparam int N_W   = 30;            // law-of-cosines numerator, signed
  localparam int NN_W  = 29;            // |n|
  localparam int N2_W  = 2 * NN_W;      // n squared
  localparam int LIM_W = LSQ_W + D2_W + 2;
  localparam int S_W   = 29;            // floor sqrt of lim - n^2
  localparam int SQRT_STAGES = 29;      // one result bit per stage

  // Vector angle unit
  localparam int VA_W   = N_W;
  localparam int VB_W   = S_W;
  localparam int CW     = 57;
  localparam int Z_W    = 26;
  localparam int ANG_W  = 16;
  localparam int CORDIC_STEPS = 23;
  localparam int NORM_TOP     = 53;
  localparam int ANG_180      = 46080;
  localparam int ANG_90       = 23040;
  localparam int ANG_90_FINE  = 5898240;
  localparam int ROUND_HALF   = 128;
  localparam int ROUND_SHIFT  = 8;
  localparam int VEC_LAT      = 3 + CORDIC_STEPS + 1;

  localparam int FRONT_STAGES = 6;
  localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + VEC_LAT + 1;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [Z_W-1:0] atan_fine(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:  r = 26'sd2949120;
      1:  r = 26'sd1740967;
      2:  r = 26'sd919879;
      3:  r = 26'sd466945;
      4:  r = 26'sd234379;
      5:  r = 26'sd117304;
      6:  r = 26'sd58666;
      7:  r = 26'sd29335;
      8:  r = 26'sd14668;
      9:  r = 26'sd7334;
      10: r = 26'sd3667;
      11: r = 26'sd1833;
      12: r = 26'sd917;
      13: r = 26'sd458;
      14: r = 26'sd229;
      15: r = 26'sd115;
      16: r = 26'sd57;
      17: r = 26'sd29;
      18: r = 26'sd14;
      19: r = 26'sd7;
      20: r = 26'sd4;
      21: r = 26'sd2;
      22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/fbik_in_if.sv
// Foot target channel: valid/ready handshake with foot_x and foot_y.
// Depends on fbik_pkg for the field widths.
interface fbik_in_if import fbik_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] foot_x;
  logic signed [COORD_W-1:0] foot_y;

  modport source (output valid, foot_x, foot_y, input ready);
  modport sink   (input valid, foot_x, foot_y, output ready);
endinterface

FILE: hw/rtl/fbik_out_if.sv
// Motor angle channel: valid/ready handshake with both angles and status.
// Depends on fbik_pkg for the field widths.
interface fbik_out_if import fbik_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] left_motor_angle;
  logic signed [ANGLE_W-1:0] right_motor_angle;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, left_motor_angle, right_motor_angle, status, input ready);
  modport sink   (input valid, left_motor_angle, right_motor_angle, status, output ready);
endinterface

FILE: hw/rtl/fbik_cfg_if.sv
// Register write channel: valid/ready handshake with register index and data.
// Depends on fbik_pkg for the field widths.
interface fbik_cfg_if import fbik_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_index;
  logic [LINK_W-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: hw/rtl/fbik_vec_angle.sv
// Pipelined vector angle unit: angle of (a, b), b >= 0, in 1/256 degree.
// Depends on fbik_pkg; every stage advances only while en is high.
module fbik_vec_angle import fbik_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [VA_W-1:0] a,
  input  logic [VB_W-1:0]        b,
  output logic [ANG_W-1:0]       angle
);

  typedef struct packed {
    logic signed [CW-1:0]  a;
    logic signed [CW-1:0]  b;
    logic signed [Z_W-1:0] z;
    logic                  special;
    logic [ANG_W-1:0]      spec_val;
  } vec_t;

  vec_t             pre, pre_next;
  vec_t             norm1, norm1_next;
  vec_t             norm2, norm2_next;
  vec_t             cs [CORDIC_STEPS];
  vec_t             cs_next [CORDIC_STEPS];
  logic [ANG_W-1:0] angle_next;

  // Rotate a left-pointing vector by 90 degrees, then double both parts.
  always_comb begin
    pre_next = '0;
    pre_next.special = (b == '0);
    if (a == '0) begin
      pre_next.spec_val = ANG_W'(ANG_90);
    end else if (a < 0) begin
      pre_next.spec_val = ANG_W'(ANG_180);
    end else begin
      pre_next.spec_val = '0;
    end
    if (a < 0) begin
      pre_next.a = CW'(b) <<< 1;
      pre_next.b = (-CW'(a)) <<< 1;
      pre_next.z = Z_W'(ANG_90_FINE);
    end else begin
      pre_next.a = CW'(a) <<< 1;
      pre_next.b = CW'(b) <<< 1;
      pre_next.z = '0;
    end
  end

  // Normalise: shift up while the larger part stays below 2^53.
  always_comb begin
    logic [CW-1:0] m;
    norm1_next = pre;
    for (int j = 5; j >= 3; j--) begin
      m = norm1_next.a | norm1_next.b;
      if ((m >> (NORM_TOP - (1 << j))) == '0) begin
        norm1_next.a = norm1_next.a <<< (1 << j);
        norm1_next.b = norm1_next.b <<< (1 << j);
      end
    end
  end

  always_comb begin
    logic [CW-1:0] m;
    norm2_next = norm1;
    for (int j = 2; j >= 0; j--) begin
      m = norm2_next.a | norm2_next.b;
      if ((m >> (NORM_TOP - (1 << j))) == '0) begin
        norm2_next.a = norm2_next.a <<< (1 << j);
        norm2_next.b = norm2_next.b <<< (1 << j);
      end
    end
  end

  // One vectoring step per stage
  always_comb begin
    vec_t src;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      src = (i == 0) ? norm2 : cs[i-1];
      cs_next[i] = src;
      if (src.b > 0) begin
        cs_next[i].a = src.a + (src.b >>> i);
        cs_next[i].b = src.b - (src.a >>> i);
        cs_next[i].z = src.z + atan_fine(i);
      end else begin
        cs_next[i].a = src.a - (src.b >>> i);
        cs_next[i].b = src.b + (src.a >>> i);
        cs_next[i].z = src.z - atan_fine(i);
      end
    end
  end

  // Round to 1/256 degree and limit to the half turn.
  always_comb begin
    logic signed [Z_W-1:0] zr;
    zr = (cs[CORDIC_STEPS-1].z + Z_W'(ROUND_HALF)) >>> ROUND_SHIFT;
    if (cs[CORDIC_STEPS-1].special) begin
      angle_next = cs[CORDIC_STEPS-1].spec_val;
    end else if (zr < 0) begin
      angle_next = '0;
    end else if (zr > Z_W'(ANG_180)) begin
      angle_next = ANG_W'(ANG_180);
    end else begin
      angle_next = zr[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre   <= pre_next;
      norm1 <= norm1_next;
      norm2 <= norm2_next;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cs[i] <= cs_next[i];
      end
      angle <= angle_next;
    end
  end

endmodule

FILE: hw/rtl/five_bar_leg_inverse_kinematics_top.sv
// Five-bar leg inverse kinematics: foot target in, two motor angles and status out.
// Depends on fbik_pkg, the three channel interfaces, fbik_vec_angle and assert_macros.svh.
//
// Usage:
//   cfg    - register writes (upper link, lower link, pivot height), always ready.
//            Write only while no item is in flight.
//   target - foot_x / foot_y items, accepted when valid and ready are both high.
//   angles - left/right motor angle in 1/256 degree plus status
//            (ok, cosine clamped, target at pivot).
// Throughput is one item per cycle while angles is not stalled. The pipeline is 63
// register stages deep. The stages are six of squares, products and the reach
// compare, 29 of square root (one result bit per stage), 27 in the two vector
// angle units (rotate, normalise in two stages, 23 CORDIC steps, round) and the
// output register.
// The whole pipeline advances as one; when angles is stalled with a result
// waiting, target.ready drops and every stage holds, so nothing is lost or repeated.
// Reset clears the valid bits and loads the link lengths and pivot height with
// their defaults.
`include "assert_macros.svh"

module five_bar_leg_inverse_kinematics_top import fbik_pkg::*; (
  input logic      clk,
  input logic      rst,
  fbik_cfg_if.sink cfg,
  fbik_in_if.sink  target,
  fbik_out_if.source angles
);

  typedef struct packed {
    logic signed [N_W-1:0] n;
    logic signed [U_W-1:0] u;
    logic [AX_W-1:0]       ax;
    logic                  xle0;
    logic                  pivot;
    logic                  clamp;
  } side_t;

  typedef struct packed {
    logic nneg;
    logic xle0;
    logic pivot;
    logic clamp;
  } tail_t;

  logic [LINK_W-1:0] upper_link;
  logic [LINK_W-1:0] lower_link;
  logic [LINK_W-1:0] pivot_h;

  logic [PIPE_DEPTH-1:0] vld;
  logic                  en;

  side_t side1_next, side4_next, side6_next;
  side_t s1_side, s2_side, s3_side, s4_side, s5_side, s6_side;
  logic [SQ_W-1:0]  s2_xx, s2_uu;
  logic [LSQ_W-1:0] s2_l1sq, s2_l2sq, s3_l1sq, s3_l2sq;
  logic [D2_W-1:0]  s3_d2;
  logic [LIM_W-1:0] s4_lim, s5_lim, s6_rem;
  logic [N2_W-1:0]  s5_n2;

  logic [2*AX_W-1:0]       xx_full;
  logic signed [2*U_W-1:0] uu_full;
  logic [LSQ_W-1:0]        l1sq_next, l2sq_next;
  logic [LIM_W-3:0]        lim_prod;
  logic [NN_W-1:0]         nn;
  logic [N2_W-1:0]         n2_next;

  logic [LIM_W-1:0] sq_v [SQRT_STAGES];
  logic [LIM_W-1:0] sq_r [SQRT_STAGES];
  logic [LIM_W-1:0] sq_v_next [SQRT_STAGES];
  logic [LIM_W-1:0] sq_r_next [SQRT_STAGES];
  side_t            sq_side [SQRT_STAGES];
  side_t            sq_last;

  tail_t            tl [VEC_LAT];
  logic [ANG_W-1:0] ang1, ang2;

  logic signed [ANGLE_W-1:0] a1, a2, ang_sum, ang_diff;
  logic signed [ANGLE_W:0]   out_pair_sum;

  // Register writes; an index beyond the list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link <= UPPER_LINK_RST;
      lower_link <= LOWER_LINK_RST;
      pivot_h    <= PIVOT_HEIGHT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_UPPER_LINK:   upper_link <= cfg.wdata;
        REG_LOWER_LINK:   lower_link <= cfg.wdata;
        REG_PIVOT_HEIGHT: pivot_h    <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Single enable for the whole pipeline: advance unless the output is held.
  assign en           = !vld[PIPE_DEPTH-1] || angles.ready;
  assign target.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], target.valid};
    end
  end

  always_comb begin
    side1_next      = '0;
    side1_next.u    = $signed({{(U_W-LINK_W){1'b0}}, pivot_h}) - U_W'(target.foot_y);
    side1_next.ax   = target.foot_x[COORD_W-1] ? AX_W'(-target.foot_x) : AX_W'(target.foot_x);
    side1_next.xle0 = target.foot_x[COORD_W-1] || (target.foot_x == '0);
  end

  always_comb begin
    side4_next       = s3_side;
    side4_next.n     = N_W'(s3_l1sq) + N_W'(s3_d2) - N_W'(s3_l2sq);
    side4_next.pivot = (s3_d2 == '0);
  end

  always_comb begin
    side6_next       = s5_side;
    side6_next.clamp = ({1'b0, s5_lim} < s5_n2);
  end

  assign xx_full   = s1_side.ax * s1_side.ax;
  assign uu_full   = s1_side.u * s1_side.u;
  assign l1sq_next = upper_link * upper_link;
  assign l2sq_next = lower_link * lower_link;
  assign lim_prod  = s3_l1sq * s3_d2;
  assign nn        = s4_side.n[N_W-1] ? NN_W'(-s4_side.n) : NN_W'(s4_side.n);
  assign n2_next   = nn * nn;

  // Front end: squares, distance, numerator, reach limit and compare.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side <= side1_next;

      s2_side <= s1_side;
      s2_xx   <= xx_full[SQ_W-1:0];
      s2_uu   <= uu_full[SQ_W-1:0];
      s2_l1sq <= l1sq_next;
      s2_l2sq <= l2sq_next;

      s3_side <= s2_side;
      s3_d2   <= D2_W'(s2_xx) + D2_W'(s2_uu);
      s3_l1sq <= s2_l1sq;
      s3_l2sq <= s2_l2sq;

      s4_side <= side4_next;
      s4_lim  <= {lim_prod, 2'b00};

      s5_side <= s4_side;
      s5_n2   <= n2_next;
      s5_lim  <= s4_lim;

      s6_side <= side6_next;
      s6_rem  <= s5_lim - s5_n2[LIM_W-1:0];
    end
  end

  // Integer square root, one result bit per stage.
  always_comb begin
    logic [LIM_W-1:0] v_in, r_in, bitv, t;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      v_in = (k == 0) ? s6_rem : sq_v[k-1];
      r_in = (k == 0) ? '0 : sq_r[k-1];
      bitv = LIM_W'(1) << (2 * (SQRT_STAGES - 1 - k));
      t    = r_in + bitv;
      if (v_in >= t) begin
        sq_v_next[k] = v_in - t;
        sq_r_next[k] = (r_in >> 1) + bitv;
      end else begin
        sq_v_next[k] = v_in;
        sq_r_next[k] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        sq_v[k]    <= sq_v_next[k];
        sq_r[k]    <= sq_r_next[k];
        sq_side[k] <= (k == 0) ? s6_side : sq_side[k-1];
      end
    end
  end

  assign sq_last = sq_side[SQRT_STAGES-1];

  fbik_vec_angle u_pivot_angle (
    .clk   (clk),
    .en    (en),
    .a     (VA_W'(sq_last.u)),
    .b     (VB_W'(sq_last.ax)),
    .angle (ang1)
  );

  fbik_vec_angle u_knee_angle (
    .clk   (clk),
    .en    (en),
    .a     (sq_last.n),
    .b     (sq_r[SQRT_STAGES-1][S_W-1:0]),
    .angle (ang2)
  );

  // Carry the flags alongside the angle units.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < VEC_LAT; j++) begin
        if (j == 0) begin
          tl[j] <= '{nneg: sq_last.n[N_W-1], xle0: sq_last.xle0,
                     pivot: sq_last.pivot, clamp: sq_last.clamp};
        end else begin
          tl[j] <= tl[j-1];
        end
      end
    end
  end

  always_comb begin
    a1 = ANGLE_W'(ang1);
    if (tl[VEC_LAT-1].clamp) begin
      a2 = tl[VEC_LAT-1].nneg ? ANGLE_W'(ANG_180) : '0;
    end else begin
      a2 = ANGLE_W'(ang2);
    end
    ang_sum  = a1 + a2;
    ang_diff = a2 - a1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tl[VEC_LAT-1].pivot) begin
        angles.left_motor_angle  <= '0;
        angles.right_motor_angle <= '0;
        angles.status            <= ST_PIVOT;
      end else begin
        angles.left_motor_angle  <= tl[VEC_LAT-1].xle0 ? ang_sum : ang_diff;
        angles.right_motor_angle <= tl[VEC_LAT-1].xle0 ? ang_diff : ang_sum;
        angles.status            <= tl[VEC_LAT-1].clamp ? ST_CLAMP : ST_OK;
      end
    end
  end

  assign angles.valid = vld[PIPE_DEPTH-1];

  assign out_pair_sum = (ANGLE_W+1)'(angles.left_motor_angle)
                      + (ANGLE_W+1)'(angles.right_motor_angle);

  `FBIK_ASSERT_IMP(a_pivot_zero, angles.valid && (angles.status == ST_PIVOT), (angles.left_motor_angle == '0) && (angles.right_motor_angle == '0))
  `FBIK_ASSERT_IMP(a_pair_parity, angles.valid, angles.left_motor_angle[0] == angles.right_motor_angle[0])
  `FBIK_ASSERT_IMP(a_clamp_sum, angles.valid && (angles.status == ST_CLAMP), (out_pair_sum == '0) || (out_pair_sum == (ANGLE_W+1)'(2 * ANG_180)))
  `FBIK_ASSERT_NEXT(a_entry_advance, vld[0] && en, vld[1])

endmodule
